// ===== sv/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
// No dependencies; imported by modular_exponentiation_top.
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

	// Width of every data port, independent of the internal WIDTH parameter.
	localparam int unsigned PORT_W = 64;

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_RED_B   = 7'b0000010,
		S_DEC     = 7'b0000100,
		S_MUL_ACC = 7'b0001000,
		S_MUL_SQ  = 7'b0010000,
		S_RED_N   = 7'b0100000,
		S_FINAL   = 7'b1000000
	} mexp_state_t;

endpackage

`default_nettype wire

// ===== sv/modular_exponentiation_top.sv =====
// Modular exponentiation by right-to-left square and multiply, with a single
// bit-serial modular multiplier shared by every step. Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals                                  Transfer when
// input     in         cmd, base, exponent, numerator           in_valid & in_ready
// output    out        value, error                             out_valid & out_ready
// config    in         cfg_wdata (modulus)                      cfg_we
//
// One item takes up to 2*WIDTH+3 modular multiplications in the shared
// add-and-reduce unit (one doubling per bit of the multiplier, plus one add per
// set bit). The loop ends early once the remaining exponent bits are all zero.
// Reset clears the modulus to 0 and returns the sequencer to idle.
// in_ready is high only while idle; a finished result waits in the output
// register, and the next input is taken once that result has been transferred.

module modular_exponentiation_top #(
	parameter int unsigned WIDTH = 64
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [mexp_pkg::PORT_W-1:0] cfg_wdata,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire                         cmd,
	input  wire  [mexp_pkg::PORT_W-1:0] base,
	input  wire  [mexp_pkg::PORT_W-1:0] exponent,
	input  wire  [mexp_pkg::PORT_W-1:0] numerator,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [mexp_pkg::PORT_W-1:0] value,
	output logic                        error
);
	import mexp_pkg::*;

	localparam int unsigned CW = $clog2(WIDTH);

	mexp_state_t state_q;

	logic [PORT_W-1:0] mod_q;     // configuration register
	logic [WIDTH-1:0]  m_q;       // modulus latched for the current item
	logic              cmd_q;
	logic [WIDTH-1:0]  acc_q;     // running product
	logic [WIDTH-1:0]  sq_q;      // running square
	logic [WIDTH-1:0]  exp_q;     // remaining exponent bits
	logic [WIDTH-1:0]  num_q;
	logic [WIDTH-1:0]  ma_q;      // multiplicand, already reduced
	logic [WIDTH-1:0]  mb_q;      // multiplier, scanned from its top bit
	logic [WIDTH-1:0]  mp_q;      // partial product
	logic [CW-1:0]     cnt_q;
	logic              ph_q;      // 0: doubling step, 1: add step
	logic [WIDTH-1:0]  val_q;
	logic              err_q;
	logic              ovalid_q;

	// Shared add-and-reduce unit: mp + (ph ? ma : mp), reduced once by m.
	// Both operands are below m when m is not zero, so one subtraction suffices.
	logic [WIDTH:0]   sum;
	logic [WIDTH-1:0] sum_red;
	logic             mul_busy;
	logic             mul_done;
	logic [WIDTH-1:0] in_mod;
	logic [WIDTH-1:0] one_red;

	assign in_mod   = mod_q[WIDTH-1:0];
	// The value 1 reduced by the modulus: 0 only for a modulus of one.
	assign one_red  = (m_q == WIDTH'(1)) ? '0 : WIDTH'(1);

	assign sum = {1'b0, mp_q} + {1'b0, (ph_q ? ma_q : mp_q)};
	always_comb begin
		if (m_q != '0 && sum >= {1'b0, m_q}) begin
			sum_red = WIDTH'(sum - {1'b0, m_q});
		end else begin
			sum_red = sum[WIDTH-1:0];
		end
	end

	assign mul_busy = (state_q == S_RED_B) || (state_q == S_MUL_ACC) ||
		(state_q == S_MUL_SQ) || (state_q == S_RED_N) || (state_q == S_FINAL);
	// A product is finished after the add step of its last bit, or after the doubling when that bit is clear.
	assign mul_done = mul_busy && (ph_q || !mb_q[WIDTH-1]) && (cnt_q == '0);

	assign in_ready  = (state_q == S_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;
	assign value     = PORT_W'(val_q);
	assign error     = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= '0;
		end else if (cfg_we) begin
			mod_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
			ph_q     <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (ovalid_q && out_ready) begin
				ovalid_q <= 1'b0;
			end

			// Bit-serial multiplier stepping; the final step is taken over by the
			// state logic below, which captures the product or starts the next one.
			if (mul_busy && !mul_done) begin
				mp_q <= sum_red;
				if (!ph_q && mb_q[WIDTH-1]) begin
					ph_q <= 1'b1;
				end else begin
					ph_q  <= 1'b0;
					mb_q  <= mb_q << 1;
					cnt_q <= cnt_q - CW'(1);
				end
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						m_q   <= in_mod;
						cmd_q <= cmd;
						num_q <= numerator[WIDTH-1:0];
						exp_q <= cmd ? (in_mod - WIDTH'(2)) : exponent[WIDTH-1:0];
						acc_q <= (in_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
						if (cmd && in_mod < WIDTH'(2)) begin
							val_q    <= '0;
							err_q    <= 1'b1;
							ovalid_q <= 1'b1;
						end else if (in_mod == '0) begin
							sq_q    <= base[WIDTH-1:0];
							state_q <= S_DEC;
						end else begin
							// Reduce the base: 1 * base mod m.
							ma_q    <= (in_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
							mb_q    <= base[WIDTH-1:0];
							mp_q    <= '0;
							cnt_q   <= CW'(WIDTH - 1);
							ph_q    <= 1'b0;
							state_q <= S_RED_B;
						end
					end
				end
				S_RED_B: begin
					if (mul_done) begin
						sq_q    <= sum_red;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					mp_q  <= '0;
					cnt_q <= CW'(WIDTH - 1);
					ph_q  <= 1'b0;
					if (exp_q == '0) begin
						if (cmd_q) begin
							ma_q    <= one_red;
							mb_q    <= num_q;
							state_q <= S_RED_N;
						end else begin
							val_q    <= acc_q;
							err_q    <= 1'b0;
							ovalid_q <= 1'b1;
							state_q  <= S_IDLE;
						end
					end else if (exp_q[0]) begin
						ma_q    <= acc_q;
						mb_q    <= sq_q;
						state_q <= S_MUL_ACC;
					end else begin
						ma_q    <= sq_q;
						mb_q    <= sq_q;
						state_q <= S_MUL_SQ;
					end
				end
				S_MUL_ACC: begin
					if (mul_done) begin
						acc_q   <= sum_red;
						ma_q    <= sq_q;
						mb_q    <= sq_q;
						mp_q    <= '0;
						cnt_q   <= CW'(WIDTH - 1);
						ph_q    <= 1'b0;
						state_q <= S_MUL_SQ;
					end
				end
				S_MUL_SQ: begin
					if (mul_done) begin
						sq_q    <= sum_red;
						exp_q   <= exp_q >> 1;
						state_q <= S_DEC;
					end
				end
				S_RED_N: begin
					if (mul_done) begin
						// Reduced numerator times the inverse.
						ma_q    <= sum_red;
						mb_q    <= acc_q;
						mp_q    <= '0;
						cnt_q   <= CW'(WIDTH - 1);
						ph_q    <= 1'b0;
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					if (mul_done) begin
						val_q    <= sum_red;
						err_q    <= 1'b0;
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// An error result always carries a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error) |-> (value == '0))
		else $error("error result with nonzero value");

	// A normal result is fully reduced by the item's modulus.
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !error && m_q != '0) |-> (val_q < m_q))
		else $error("result not below modulus");

	// The add step only follows a doubling step on a set multiplier bit.
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_busy && ph_q && !mul_done) |=> !ph_q)
		else $error("two add steps in a row");

	// The multiplier is never stepping while the block offers to take input.
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !mul_busy && !out_valid)
		else $error("ready while busy");

endmodule

`default_nettype wire
